// ----- rtl/core/rgb_subpixel_triplet_spill_defines.svh -----
// assertion macros for the rgb subpixel triplet spill block
// no dependencies; compiled out when SYNTH is defined
`ifndef RGB_SUBPIXEL_TRIPLET_SPILL_DEFINES_SVH
`define RGB_SUBPIXEL_TRIPLET_SPILL_DEFINES_SVH
`ifndef SYNTH
`define RGBST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rgbst assertion failed");
`define RGBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbst assertion failed");
`else
`define RGBST_ASSERT(lbl, clk, rst_n, prop)
`define RGBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/rgbst_pkg.sv -----
// shared types and constants for the rgb subpixel triplet spill block
// no dependencies
package rgbst_pkg;

    localparam int CHAN_W = 8;
    localparam int BLUR_W = 9;
    localparam int WEIGHT_W = 10;
    localparam int FRAC_SHIFT = 8;

    localparam logic [WEIGHT_W-1:0] MAIN_WEIGHT_FULL = 10'd768;
    localparam logic [BLUR_W-1:0] BLUR_MAIN_LIMIT = 9'd384;
    localparam logic [WEIGHT_W-1:0] CHAN_MAX = 10'd255;

    localparam logic [1:0] Q_DEPTH = 2'd2;

    typedef logic [1:0] t_cnt;

    typedef struct packed {
        logic [CHAN_W-1:0] left_red;
        logic [CHAN_W-1:0] left_green;
        logic [CHAN_W-1:0] left_blue;
        logic [CHAN_W-1:0] mid_red;
        logic [CHAN_W-1:0] mid_green;
        logic [CHAN_W-1:0] mid_blue;
        logic [CHAN_W-1:0] right_red;
        logic [CHAN_W-1:0] right_green;
        logic [CHAN_W-1:0] right_blue;
        logic              line_done;
        logic              run_end;
    } t_triplet;

    // up to two triplets written into the output queue in one cycle
    typedef struct packed {
        t_cnt     cnt;
        t_triplet first;
        t_triplet second;
    } t_push;

endpackage

// ----- rtl/core/rgbst_split.sv -----
// splits one channel value into its main and spill parts
// depends on rgbst_pkg
module rgbst_split (
    input  logic [rgbst_pkg::BLUR_W-1:0] i_blur,
    input  logic [rgbst_pkg::CHAN_W-1:0] i_x,
    output logic [rgbst_pkg::CHAN_W-1:0] o_main,
    output logic [rgbst_pkg::CHAN_W-1:0] o_spill
);

    logic [rgbst_pkg::WEIGHT_W-1:0] w_main_weight;
    logic [17:0] w_main_prod;
    logic [16:0] w_spill_prod;
    logic [rgbst_pkg::WEIGHT_W-1:0] w_main_raw;
    logic [8:0] w_spill_raw;
    logic [rgbst_pkg::WEIGHT_W-1:0] w_excess;
    logic [rgbst_pkg::WEIGHT_W-1:0] w_spill_sum;

    always_comb begin
        // main weight goes to zero once twice the blur passes 768
        if (i_blur <= rgbst_pkg::BLUR_MAIN_LIMIT) begin
            w_main_weight = rgbst_pkg::MAIN_WEIGHT_FULL - {i_blur, 1'b0};
        end else begin
            w_main_weight = '0;
        end
        w_main_prod  = 18'(w_main_weight) * 18'(i_x);
        w_spill_prod = 17'(i_blur) * 17'(i_x);
        w_main_raw   = w_main_prod[17:rgbst_pkg::FRAC_SHIFT];
        w_spill_raw  = w_spill_prod[16:rgbst_pkg::FRAC_SHIFT];
        w_excess     = '0;
        if (w_main_raw > rgbst_pkg::CHAN_MAX) begin
            w_excess = (w_main_raw - rgbst_pkg::CHAN_MAX) >> 1;
            o_main   = rgbst_pkg::CHAN_MAX[rgbst_pkg::CHAN_W-1:0];
        end else begin
            o_main   = w_main_raw[rgbst_pkg::CHAN_W-1:0];
        end
        // half the clipped excess spills over, then saturate
        w_spill_sum = {1'b0, w_spill_raw} + w_excess;
        if (w_spill_sum > rgbst_pkg::CHAN_MAX) begin
            o_spill = rgbst_pkg::CHAN_MAX[rgbst_pkg::CHAN_W-1:0];
        end else begin
            o_spill = w_spill_sum[rgbst_pkg::CHAN_W-1:0];
        end
    end

endmodule

// ----- rtl/core/rgbst_oq.sv -----
// two-entry result queue; head entry drives the output channel
// depends on rgbst_pkg and the assertion macro header
`include "rgb_subpixel_triplet_spill_defines.svh"
module rgbst_oq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbst_pkg::t_push    i_push,
    output rgbst_pkg::t_cnt     o_count,
    output logic                o_valid,
    input  logic                i_ready,
    output rgbst_pkg::t_triplet o_head
);

    rgbst_pkg::t_triplet r_head, n_head;
    rgbst_pkg::t_triplet r_tail, n_tail;
    rgbst_pkg::t_cnt     r_count, n_count;
    logic                w_pop;
    rgbst_pkg::t_cnt     w_left;

    always_comb begin
        w_pop   = (r_count != '0) & i_ready;
        w_left  = 2'(r_count - {1'b0, w_pop});
        n_head  = r_head;
        n_tail  = r_tail;
        if (w_pop) begin
            n_head = r_tail;
        end
        case (w_left)
            2'd0: begin
                if (i_push.cnt != '0) begin
                    n_head = i_push.first;
                end
                if (i_push.cnt == 2'd2) begin
                    n_tail = i_push.second;
                end
            end
            2'd1: begin
                if (i_push.cnt != '0) begin
                    n_tail = i_push.first;
                end
            end
            default: begin
            end
        endcase
        n_count = 2'(w_left + i_push.cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_head  = r_head;

    `RGBST_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= rgbst_pkg::Q_DEPTH)
    `RGBST_ASSERT(a_push_fits, i_clk, i_rst_n, 3'(w_left) + 3'(i_push.cnt) <= 3'(rgbst_pkg::Q_DEPTH))
    `RGBST_ASSERT_NEXT(a_two_push_seen, i_clk, i_rst_n, i_push.cnt == 2'd2, r_count == 2'd2)

endmodule

// ----- rtl/core/rgb_subpixel_triplet_spill.sv -----
// top level: input register, channel split, triplet assembly and line state
// depends on rgbst_pkg, rgbst_split, rgbst_oq and the assertion macro header
`include "rgb_subpixel_triplet_spill_defines.svh"
// a pixel's triplet is built when its completing beat leaves the input register
//   (next pixel's beat, or own beat at line end) and is registered in the queue
// throughput: one pixel per cycle; a line's first pixel makes no triplet and its
//   last makes two, so the two-entry result queue keeps pace
// the input stalls only while results back up behind a stalled output
// reset: blur factor 0, no pixel held, input register and result queue empty
module rgb_subpixel_triplet_spill (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rgbst_pkg::BLUR_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rgbst_pkg::CHAN_W-1:0] i_in_red,
    input  logic [rgbst_pkg::CHAN_W-1:0] i_in_green,
    input  logic [rgbst_pkg::CHAN_W-1:0] i_in_blue,
    input  logic                         i_line_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rgbst_pkg::CHAN_W-1:0] o_left_red,
    output logic [rgbst_pkg::CHAN_W-1:0] o_left_green,
    output logic [rgbst_pkg::CHAN_W-1:0] o_left_blue,
    output logic [rgbst_pkg::CHAN_W-1:0] o_mid_red,
    output logic [rgbst_pkg::CHAN_W-1:0] o_mid_green,
    output logic [rgbst_pkg::CHAN_W-1:0] o_mid_blue,
    output logic [rgbst_pkg::CHAN_W-1:0] o_right_red,
    output logic [rgbst_pkg::CHAN_W-1:0] o_right_green,
    output logic [rgbst_pkg::CHAN_W-1:0] o_right_blue,
    output logic                         o_line_done,
    output logic                         o_run_end
);

    logic [rgbst_pkg::BLUR_W-1:0] r_blur;

    logic                         r_in_valid;
    logic [rgbst_pkg::CHAN_W-1:0] r_red, r_green, r_blue;
    logic                         r_line_end;

    // held pixel waiting for its right neighbour
    logic                         r_pending, n_pending;
    logic [rgbst_pkg::CHAN_W-1:0] r_held_rm, n_held_rm, r_held_rs, n_held_rs;
    logic [rgbst_pkg::CHAN_W-1:0] r_held_gm, n_held_gm, r_held_gs, n_held_gs;
    logic [rgbst_pkg::CHAN_W-1:0] r_held_bm, n_held_bm, r_held_bs, n_held_bs;
    logic [rgbst_pkg::CHAN_W-1:0] r_older_bs, n_older_bs;

    logic [rgbst_pkg::CHAN_W-1:0] w_rm, w_rs, w_gm, w_gs, w_bm, w_bs;
    logic [rgbst_pkg::CHAN_W-1:0] w_prev_bs;
    rgbst_pkg::t_cnt              w_nres;
    rgbst_pkg::t_cnt              w_count;
    logic                         w_pop;
    rgbst_pkg::t_cnt              w_free;
    logic                         w_process;
    rgbst_pkg::t_triplet          w_held_trip, w_new_trip, w_head;
    rgbst_pkg::t_push             w_push;

    rgbst_split u_split_red (
        .i_blur  (r_blur),
        .i_x     (r_red),
        .o_main  (w_rm),
        .o_spill (w_rs)
    );

    rgbst_split u_split_green (
        .i_blur  (r_blur),
        .i_x     (r_green),
        .o_main  (w_gm),
        .o_spill (w_gs)
    );

    rgbst_split u_split_blue (
        .i_blur  (r_blur),
        .i_x     (r_blue),
        .o_main  (w_bm),
        .o_spill (w_bs)
    );

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_nres    = 2'({1'b0, r_pending} + {1'b0, r_line_end});
        // a beat leaving the queue this cycle frees its slot
        w_pop     = o_out_valid && i_out_ready;
        w_free    = 2'(w_count - {1'b0, w_pop});
        w_process = r_in_valid && ((3'(w_free) + 3'(w_nres)) <= 3'(rgbst_pkg::Q_DEPTH));
        w_prev_bs = r_pending ? r_held_bs : '0;

        w_held_trip.left_red    = r_held_rm;
        w_held_trip.left_green  = r_held_gs;
        w_held_trip.left_blue   = r_older_bs;
        w_held_trip.mid_red     = r_held_rs;
        w_held_trip.mid_green   = r_held_gm;
        w_held_trip.mid_blue    = r_held_bs;
        w_held_trip.right_red   = w_rs;
        w_held_trip.right_green = r_held_gs;
        w_held_trip.right_blue  = r_held_bm;
        w_held_trip.line_done   = 1'b0;
        w_held_trip.run_end     = !r_line_end;

        w_new_trip.left_red    = w_rm;
        w_new_trip.left_green  = w_gs;
        w_new_trip.left_blue   = w_prev_bs;
        w_new_trip.mid_red     = w_rs;
        w_new_trip.mid_green   = w_gm;
        w_new_trip.mid_blue    = w_bs;
        w_new_trip.right_red   = '0;
        w_new_trip.right_green = w_gs;
        w_new_trip.right_blue  = w_bm;
        w_new_trip.line_done   = 1'b1;
        w_new_trip.run_end     = 1'b1;

        w_push.cnt    = w_process ? w_nres : '0;
        w_push.first  = r_pending ? w_held_trip : w_new_trip;
        w_push.second = w_new_trip;

        n_pending  = r_pending;
        n_held_rm  = r_held_rm;
        n_held_rs  = r_held_rs;
        n_held_gm  = r_held_gm;
        n_held_gs  = r_held_gs;
        n_held_bm  = r_held_bm;
        n_held_bs  = r_held_bs;
        n_older_bs = r_older_bs;
        if (w_process) begin
            if (r_line_end) begin
                n_pending  = 1'b0;
                n_older_bs = '0;
            end else begin
                n_pending  = 1'b1;
                n_older_bs = w_prev_bs;
                n_held_rm  = w_rm;
                n_held_rs  = w_rs;
                n_held_gm  = w_gm;
                n_held_gs  = w_gs;
                n_held_bm  = w_bm;
                n_held_bs  = w_bs;
            end
        end
    end

    assign o_in_ready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur     <= '0;
            r_in_valid <= 1'b0;
            r_pending  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_blur <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_red      <= i_in_red;
            r_green    <= i_in_green;
            r_blue     <= i_in_blue;
            r_line_end <= i_line_end;
        end
        r_held_rm  <= n_held_rm;
        r_held_rs  <= n_held_rs;
        r_held_gm  <= n_held_gm;
        r_held_gs  <= n_held_gs;
        r_held_bm  <= n_held_bm;
        r_held_bs  <= n_held_bs;
        r_older_bs <= n_older_bs;
    end

    rgbst_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (w_head)
    );

    assign o_left_red    = w_head.left_red;
    assign o_left_green  = w_head.left_green;
    assign o_left_blue   = w_head.left_blue;
    assign o_mid_red     = w_head.mid_red;
    assign o_mid_green   = w_head.mid_green;
    assign o_mid_blue    = w_head.mid_blue;
    assign o_right_red   = w_head.right_red;
    assign o_right_green = w_head.right_green;
    assign o_right_blue  = w_head.right_blue;
    assign o_line_done   = w_head.line_done;
    assign o_run_end     = w_head.run_end;

    `RGBST_ASSERT_NEXT(a_line_end_clears, i_clk, i_rst_n, w_process && r_line_end, !r_pending)
    `RGBST_ASSERT_NEXT(a_mid_line_holds, i_clk, i_rst_n, w_process && !r_line_end, r_pending)
    `RGBST_ASSERT(a_held_needs_room, i_clk, i_rst_n, !(w_process && w_nres[1] && w_count[1]))

endmodule
